### src/rsf_pkg.sv
package rsf_pkg;

  // address arithmetic width, pixel address port stays 24 bits
  localparam int ADDR_BITS = 24;
  localparam int COL_BITS = 16;
  localparam int LEN_BITS = 6;
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_BASE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STRIDE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_COLOR = 3'd4;

  // code bytes
  localparam logic [7:0] CODE_A = 8'h41;
  localparam logic [7:0] CODE_B = 8'h42;
  localparam logic [7:0] CODE_C = 8'h43;
  localparam logic [7:0] CODE_D = 8'h44;
  localparam logic [7:0] CODE_E = 8'h45;
  localparam logic [7:0] CODE_F = 8'h46;
  localparam logic [7:0] CODE_G = 8'h47;
  localparam logic [7:0] CODE_H = 8'h48;
  localparam logic [7:0] CODE_I = 8'h49;
  localparam logic [7:0] CODE_J = 8'h4A;
  localparam logic [7:0] CODE_K = 8'h4B;
  localparam logic [7:0] CODE_L = 8'h4C;
  localparam logic [7:0] CODE_N = 8'h4E;
  localparam logic [7:0] CODE_S = 8'h53;
  localparam logic [7:0] CODE_T = 8'h54;
  localparam logic [7:0] CODE_U = 8'h55;
  localparam logic [7:0] CODE_V = 8'h56;
  localparam logic [7:0] CODE_ONE = 8'h31;
  localparam logic [7:0] CODE_ROW_END = 8'h38;

  // register reset values
  localparam logic [23:0] FRAME_BASE_RST = 24'd0;
  localparam logic [11:0] ROW_STRIDE_RST = 12'd320;
  localparam logic [11:0] ORIGIN_X_RST = 12'd0;
  localparam logic [11:0] ORIGIN_Y_RST = 12'd0;
  localparam logic [7:0] DRAW_COLOR_RST = 8'd7;

  typedef struct packed {
    logic [7:0] code_char;
    logic       new_image;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_address;
    logic [7:0]  pixel_color;
    logic        run_last;
  } out_item_t;

  // one paint run handed from front to back
  typedef struct packed {
    logic [ADDR_BITS-1:0] start_addr;
    logic [LEN_BITS-1:0]  len;
  } run_cmd_t;

  typedef struct packed {
    logic [23:0] frame_base;
    logic [11:0] row_stride;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [7:0]  draw_color;
  } cfg_t;

  function automatic logic [LEN_BITS-1:0] skip_amount(input logic [7:0] code);
    logic [LEN_BITS-1:0] amt;
    unique case (code)
      CODE_A: amt = 6'd58;
      CODE_B: amt = 6'd5;
      CODE_C: amt = 6'd31;
      CODE_D: amt = 6'd24;
      CODE_E: amt = 6'd52;
      CODE_F: amt = 6'd11;
      CODE_G: amt = 6'd17;
      CODE_H: amt = 6'd12;
      CODE_I: amt = 6'd18;
      CODE_J: amt = 6'd37;
      CODE_K: amt = 6'd19;
      CODE_L: amt = 6'd7;
      CODE_N: amt = 6'd4;
      default: amt = '0;
    endcase
    return amt;
  endfunction

  function automatic logic [LEN_BITS-1:0] paint_length(input logic [7:0] code);
    logic [LEN_BITS-1:0] len;
    unique case (code)
      CODE_S: len = 6'd47;
      CODE_T: len = 6'd21;
      CODE_U: len = 6'd30;
      CODE_V: len = 6'd8;
      CODE_ONE: len = 6'd1;
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

### src/rsf_front.sv
module rsf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsf_pkg::in_item_t in_item_i,
  input  rsf_pkg::cfg_t     cfg_i,
  input  logic              cmd_full_i,
  output logic              full_o,
  output logic              cmd_push_o,
  output rsf_pkg::run_cmd_t cmd_o
);
  import rsf_pkg::*;

  logic [COL_BITS-1:0]  col_q, col_d;
  logic [ADDR_BITS-1:0] row_q, row_d;
  logic [ADDR_BITS-1:0] origin_addr;
  logic [23:0]          y_times_stride;
  logic [COL_BITS-1:0]  col_base;
  logic [ADDR_BITS-1:0] row_base;
  logic [LEN_BITS-1:0]  paint_len;
  logic                 accept;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;

  // sprite origin in the framebuffer
  assign y_times_stride = cfg_i.origin_y * cfg_i.row_stride;
  assign origin_addr = ADDR_BITS'(cfg_i.frame_base) + ADDR_BITS'(y_times_stride)
                     + ADDR_BITS'(cfg_i.origin_x);

  // position after an optional new-image reload
  assign col_base = in_item_i.new_image ? '0 : col_q;
  assign row_base = in_item_i.new_image ? origin_addr : row_q;

  assign paint_len = paint_length(in_item_i.code_char);

  // classify the code and step the position
  always_comb begin
    col_d = col_base;
    row_d = row_base;
    if (in_item_i.code_char == CODE_ROW_END) begin
      col_d = '0;
      row_d = row_base + ADDR_BITS'(cfg_i.row_stride);
    end else if (paint_len != '0) begin
      col_d = col_base + COL_BITS'(paint_len);
    end else begin
      col_d = col_base + COL_BITS'(skip_amount(in_item_i.code_char));
    end
  end

  assign cmd_push_o = accept && (in_item_i.code_char != CODE_ROW_END) && (paint_len != '0);
  assign cmd_o.start_addr = row_base + ADDR_BITS'(col_base);
  assign cmd_o.len = paint_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= ADDR_BITS'(FRAME_BASE_RST) + ADDR_BITS'(ORIGIN_Y_RST * ROW_STRIDE_RST)
             + ADDR_BITS'(ORIGIN_X_RST);
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### src/rsf_cmd_fifo.sv
module rsf_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsf_pkg::run_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rsf_pkg::run_cmd_t data_o
);
  import rsf_pkg::*;

  localparam int PTR_BITS = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(CMD_FIFO_DEPTH + 1);

  run_cmd_t            mem_q [CMD_FIFO_DEPTH];
  logic [PTR_BITS-1:0] wptr_q, rptr_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CNT_BITS'(CMD_FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_BITS'(CMD_FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_BITS'(CMD_FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### src/rsf_back.sv
module rsf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rsf_pkg::run_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic [7:0]        draw_color_i,
  input  logic              pop_i,
  output logic              empty_o,
  output rsf_pkg::out_item_t out_item_o
);
  import rsf_pkg::*;

  logic                 busy_q;
  logic [ADDR_BITS-1:0] base_q;
  logic [LEN_BITS-1:0]  len_q, idx_q;
  logic                 out_valid_q;
  out_item_t            out_q;
  logic                 out_free;
  logic                 emit;
  logic                 is_last;
  logic [ADDR_BITS-1:0] pix_addr;

  assign out_free  = !out_valid_q || pop_i;
  assign emit      = busy_q && out_free;
  assign is_last   = (idx_q == len_q - 1'b1);
  assign pix_addr  = base_q + ADDR_BITS'(idx_q);
  assign cmd_pop_o = cmd_valid_i && (!busy_q || (emit && is_last));
  assign empty_o   = !out_valid_q;
  assign out_item_o = out_q;

  // run walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (cmd_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (emit) begin
      busy_q <= !is_last;
      idx_q  <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      base_q <= cmd_i.start_addr;
      len_q  <= cmd_i.len;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.pixel_address <= 24'(pix_addr);
      out_q.pixel_color   <= draw_color_i;
      out_q.run_last      <= is_last;
    end
  end

  // walker stays inside its run
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> (idx_q < len_q))
    else $error("run index past run length");

  // a pixel that is not last keeps the run going with the next index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !is_last) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
    else $error("run ended before its last pixel");

  // a waiting pixel that is not last belongs to an active run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.run_last) |-> busy_q)
    else $error("run dropped with pixels still owed");

endmodule

### src/rle_sprite_to_framebuffer.sv
// Run-length sprite decoder: takes one code byte per cycle while the command queue
// (four runs deep) has room, and writes out one pixel per cycle from its output register
// while the reader pops. Skip, row-end and unknown codes give no pixels; a paint code
// gives 1, 8, 21, 30 or 47 pixels, so the sustained rate is set by the pixel emitter,
// and decoding of later codes runs ahead while a run drains.
module rle_sprite_to_framebuffer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  rsf_pkg::in_item_t                  in_item_i,
  output logic                               empty,
  input  logic                               pop,
  output rsf_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_we_i,
  input  logic [rsf_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rsf_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import rsf_pkg::*;

  cfg_t     cfg_q;
  logic     cmd_push, cmd_full, cmd_pop, cmd_valid;
  run_cmd_t cmd_in, cmd_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base <= FRAME_BASE_RST;
      cfg_q.row_stride <= ROW_STRIDE_RST;
      cfg_q.origin_x   <= ORIGIN_X_RST;
      cfg_q.origin_y   <= ORIGIN_Y_RST;
      cfg_q.draw_color <= DRAW_COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_BASE: cfg_q.frame_base <= cfg_data_i[23:0];
        REG_ROW_STRIDE: cfg_q.row_stride <= cfg_data_i[11:0];
        REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data_i[11:0];
        REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data_i[11:0];
        REG_DRAW_COLOR: cfg_q.draw_color <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .cmd_full_i (cmd_full),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  rsf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  rsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .draw_color_i (cfg_q.draw_color),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_item_o   (out_item_o)
  );

endmodule

### test/rle_sprite_to_framebuffer_tb.sv
`timescale 1ns / 100ps

module rle_sprite_to_framebuffer_tb;
  import rsf_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 5;
  localparam int IDLE_PCT = 7;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 40;
  localparam int CFG_SLOTS = 2 ** CFG_IDX_BITS;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  in_item_t                  code_in = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  out_item_t                 pixel_out;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i = '0;

  // shadow of the decoder: registers, column and row start address
  cfg_t                  regs;
  logic [15:0]           col_offset;
  logic [ADDR_BITS-1:0]  row_base;

  out_item_t pending_pixels[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  // meaningful codes for random sprites
  logic [7:0] skip_codes[13] = '{CODE_A, CODE_B, CODE_C, CODE_D, CODE_E, CODE_F, CODE_G,
                                 CODE_H, CODE_I, CODE_J, CODE_K, CODE_L, CODE_N};
  logic [7:0] paint_codes[5] = '{CODE_S, CODE_T, CODE_U, CODE_V, CODE_ONE};

  rle_sprite_to_framebuffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (code_in),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (pixel_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(12 * 1000000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned run_length(input logic [7:0] code);
    case (code)
      CODE_S: return 47;
      CODE_T: return 21;
      CODE_U: return 30;
      CODE_V: return 8;
      CODE_ONE: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] skip_columns(input logic [7:0] code);
    case (code)
      CODE_A: return 16'd58;
      CODE_B: return 16'd5;
      CODE_C: return 16'd31;
      CODE_D: return 16'd24;
      CODE_E: return 16'd52;
      CODE_F: return 16'd11;
      CODE_G: return 16'd17;
      CODE_H: return 16'd12;
      CODE_I: return 16'd18;
      CODE_J: return 16'd37;
      CODE_K: return 16'd19;
      CODE_L: return 16'd7;
      CODE_N: return 16'd4;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [ADDR_BITS-1:0] origin_addr();
    return ADDR_BITS'(64'(regs.frame_base) + 64'(regs.origin_y) * 64'(regs.row_stride)
                      + 64'(regs.origin_x));
  endfunction

  function automatic in_item_t mk_item(input logic [7:0] code, input logic fresh);
    in_item_t it;
    it.code_char = code;
    it.new_image = fresh;
    return it;
  endfunction

  // expected pixel writes for one accepted code byte
  task automatic decode_code(input in_item_t it);
    int unsigned run;
    logic [ADDR_BITS-1:0] a;
    out_item_t px;
    if (it.new_image) begin
      col_offset = '0;
      row_base = origin_addr();
    end
    if (it.code_char == CODE_ROW_END) begin
      col_offset = '0;
      row_base = row_base + ADDR_BITS'(regs.row_stride);
      return;
    end
    run = run_length(it.code_char);
    if (run == 0) begin
      col_offset = col_offset + skip_columns(it.code_char);
      return;
    end
    for (int unsigned i = 0; i < run; i++) begin
      a = row_base + ADDR_BITS'(col_offset) + ADDR_BITS'(i);
      px.pixel_address = a[23:0];
      px.pixel_color = regs.draw_color;
      px.run_last = (i + 1 == run);
      pending_pixels.push_back(px);
    end
    col_offset = col_offset + 16'(run);
  endtask

  // register write, shadow updated in step
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      REG_FRAME_BASE: regs.frame_base = data[23:0];
      REG_ROW_STRIDE: regs.row_stride = data[11:0];
      REG_ORIGIN_X: regs.origin_x = data[11:0];
      REG_ORIGIN_Y: regs.origin_y = data[11:0];
      REG_DRAW_COLOR: regs.draw_color = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // send one item, called and returning at a falling edge
  task automatic send_code(input in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    code_in = it;
    do @(posedge clk_i); while (full);
    decode_code(it);
    @(negedge clk_i);
  endtask

  // wait for all pixels, then for codes still in the decoder
  task automatic settle();
    push = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < REPORT_LIMIT)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // result side: random stalls
  always @(negedge clk_i) begin
    pop = calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // check each pixel write against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected pixel at address", 32'hFFFFFFFF,
                      32'(pixel_out.pixel_address));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out.pixel_address !== want.pixel_address)
          flag_mismatch("pixel_address", 32'(want.pixel_address), 32'(pixel_out.pixel_address));
        if (pixel_out.pixel_color !== want.pixel_color)
          flag_mismatch("pixel_color", 32'(want.pixel_color), 32'(pixel_out.pixel_color));
        if (pixel_out.run_last !== want.run_last)
          flag_mismatch("run_last", 32'(want.run_last), 32'(pixel_out.run_last));
      end
    end
  end

  // every code once with reset settings, plus bytes outside the code set
  task automatic test_every_code();
    send_code(mk_item(CODE_ONE, 1'b1));
    foreach (skip_codes[i]) begin
      send_code(mk_item(skip_codes[i], 1'b0));
      if (i % 3 == 0) send_code(mk_item(paint_codes[(i / 3) % 5], 1'b0));
    end
    send_code(mk_item(CODE_ROW_END, 1'b0));
    send_code(mk_item(8'h00, 1'b0));
    send_code(mk_item(CODE_V, 1'b0));
    send_code(mk_item(8'hFF, 1'b1));
    send_code(mk_item(CODE_S, 1'b0));
  endtask

  // register extremes, unused indexes, zero stride, late origin change
  task automatic test_register_extremes();
    settle();
    write_reg(REG_FRAME_BASE, 24'hFFFFFF);
    write_reg(REG_ROW_STRIDE, 24'h000FFF);
    write_reg(REG_ORIGIN_X, 24'h000FFF);
    write_reg(REG_ORIGIN_Y, 24'h000FFF);
    write_reg(REG_DRAW_COLOR, 24'h0000FF);
    for (int r = REG_DRAW_COLOR + 1; r < CFG_SLOTS; r++)
      write_reg(CFG_IDX_BITS'(r), 24'hFFFFFF);
    send_code(mk_item(CODE_ONE, 1'b1));
    send_code(mk_item(CODE_S, 1'b0));
    send_code(mk_item(CODE_ROW_END, 1'b0));
    send_code(mk_item(CODE_T, 1'b0));

    // origin moves only at the next new image
    settle();
    write_reg(REG_ORIGIN_X, 24'h000010);
    write_reg(REG_ORIGIN_Y, 24'h000002);
    send_code(mk_item(CODE_V, 1'b0));
    send_code(mk_item(CODE_V, 1'b1));

    // stride of zero, upper data bits dropped
    settle();
    write_reg(REG_FRAME_BASE, 24'h000000);
    write_reg(REG_ROW_STRIDE, 24'hABC000);
    write_reg(REG_ORIGIN_X, 24'h000000);
    write_reg(REG_ORIGIN_Y, 24'h000000);
    write_reg(REG_DRAW_COLOR, 24'hFFFF00);
    send_code(mk_item(CODE_V, 1'b1));
    send_code(mk_item(CODE_ROW_END, 1'b0));
    send_code(mk_item(CODE_V, 1'b0));
  endtask

  // run across the top of the address space
  task automatic test_address_wrap();
    settle();
    write_reg(REG_FRAME_BASE, 24'hFFFFF0);
    write_reg(REG_ROW_STRIDE, 24'h000001);
    write_reg(REG_DRAW_COLOR, 24'h00005A);
    send_code(mk_item(CODE_S, 1'b1));
    send_code(mk_item(CODE_ROW_END, 1'b0));
    send_code(mk_item(CODE_U, 1'b0));
  endtask

  function automatic logic [23:0] pick_value(input logic [23:0] lo, input logic [23:0] hi);
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return 24'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] sprite_code();
    if ($urandom_range(99) < 40) return paint_codes[$urandom_range(4)];
    return skip_codes[$urandom_range(12)];
  endfunction

  // one sprite: rows of skips and paints, most of them closed by a row end
  task automatic send_sprite(inout int budget);
    int rows;
    int codes;
    in_item_t it;
    rows = $urandom_range(4, 1);
    for (int r = 0; r < rows && budget > 0; r++) begin
      codes = $urandom_range(5, 1);
      for (int c = 0; c < codes && budget > 0; c++) begin
        it = mk_item(sprite_code(), (r == 0 && c == 0));
        // noise: any byte, new image anywhere
        if ($urandom_range(99) < 8) it = mk_item(8'($urandom), 1'($urandom));
        send_code(it);
        budget--;
      end
      if ($urandom_range(99) < 95) begin
        send_code(mk_item(CODE_ROW_END, 1'b0));
        budget--;
      end
    end
  endtask

  // random sprites under several register settings
  task automatic test_random_sprites();
    int budget;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      write_reg(REG_FRAME_BASE, pick_value(24'h000000, 24'hFFFFFF));
      write_reg(REG_ROW_STRIDE, pick_value(24'h000001, 24'h000FFF));
      write_reg(REG_ORIGIN_X, pick_value(24'h000000, 24'h000FFF));
      write_reg(REG_ORIGIN_Y, pick_value(24'h000000, 24'h000FFF));
      write_reg(REG_DRAW_COLOR, pick_value(24'h000000, 24'h0000FF));
      calm = (ph == RANDOM_PHASES / 2);
      budget = PHASE_ITEMS;
      while (budget > 0) send_sprite(budget);
    end
    calm = 1'b0;
  endtask

  initial begin
    regs.frame_base = FRAME_BASE_RST;
    regs.row_stride = ROW_STRIDE_RST;
    regs.origin_x = ORIGIN_X_RST;
    regs.origin_y = ORIGIN_Y_RST;
    regs.draw_color = DRAW_COLOR_RST;
    col_offset = '0;
    row_base = '0;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_every_code();
    test_register_extremes();
    test_address_wrap();
    test_random_sprites();

    push = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
src/rsf_pkg.sv
src/rsf_front.sv
src/rsf_cmd_fifo.sv
src/rsf_back.sv
src/rle_sprite_to_framebuffer.sv
test/rle_sprite_to_framebuffer_tb.sv
